>>> design/line_fold_with_tab_expansion_defines.svh
// ----------------------------------------------------------------------------
// Line folder assertion macros
// Shared property forms for the line folder; each expects clock and reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLD_WITH_TAB_EXPANSION_DEFINES_SVH
`define LINE_FOLD_WITH_TAB_EXPANSION_DEFINES_SVH

// same-cycle implication
`define LFTE_ASSERT_IMP(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define LFTE_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> design/lfte_pkg.sv
// ----------------------------------------------------------------------------
// Line folder package
// Widths, character codes, item types and register helpers.
// ----------------------------------------------------------------------------
package lfte_pkg;

   localparam int CHAR_W      = 8;
   localparam int COL_W       = 6;
   localparam int SUM_W       = COL_W + 1;
   localparam int MOD_CNT_W   = $clog2(SUM_W + 1);
   localparam int CFG_IDX_W   = 1;
   localparam int FRONT_DEPTH = 2;
   localparam int OUT_DEPTH   = 4;

   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

   localparam logic [COL_W-1:0] COL_SAT       = 6'd63;
   localparam logic [COL_W-1:0] REG_MIN       = 6'd1;
   localparam logic [COL_W-1:0] REG_MAX       = 6'd62;
   localparam logic [COL_W-1:0] TAB_SIZE_RST  = 6'd8;
   localparam logic [COL_W-1:0] COL_LIMIT_RST = 6'd62;

   localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE     = 1'b0;
   localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      CLS_WORD,
      CLS_SPACE,
      CLS_TAB,
      CLS_NEWLINE
   } item_class_type;

   typedef struct packed {
      item_class_type    cls;
      logic [CHAR_W-1:0] ch;
   } front_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [COL_W-1:0]  repeat_count;
      logic              last_of_run;
   } out_item_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [COL_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [COL_W-1:0] remainder;
   } mod_rsp_type;

   function automatic logic [COL_W-1:0] clamp_reg(input logic [COL_W-1:0] v);
      logic [COL_W-1:0] r;
      r = v;
      if (v < REG_MIN) r = REG_MIN;
      else if (v > REG_MAX) r = REG_MAX;
      return r;
   endfunction

   function automatic logic [COL_W-1:0] sat_col(input logic [SUM_W-1:0] s);
      logic [COL_W-1:0] r;
      r = s[COL_W-1:0];
      if (s[SUM_W-1]) r = COL_SAT;
      return r;
   endfunction

endpackage

>>> design/line_fold_with_tab_expansion.sv
// A word byte passes the front queue and the S_IDLE and S_FLUSH states before it is stored; a tab,
// or a blank that fits on the line, also passes S_WS_BLANK and the bit-serial remainder unit that finds tab stops.
// Throughput: one result per cycle while a stored word is placed and the result queue has room;
// the sequencer takes a new byte only once it is back in S_IDLE.
// Reset: synchronous; clears column, blanks, flags, word length and queues, tab_size to 8,
// column_limit to 62; the word store itself is not cleared.
// ----------------------------------------------------------------------------
// Line folder with tab expansion
// Word-wrapping text folder: queued front end, sequencer and result queue.
// ----------------------------------------------------------------------------
module line_fold_with_tab_expansion
   import lfte_pkg::*;
#(
   parameter int WORD_DEPTH = 62
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [CHAR_W-1:0]    req_in_char,
   output logic                 empty,
   input  logic                 pop,
   output logic [CHAR_W-1:0]    rsp_out_char,
   output logic [COL_W-1:0]     rsp_repeat_count,
   output logic                 rsp_last_of_run,
   input  logic                 csr_wr_en,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [COL_W-1:0]     csr_wr_data
);

   logic [COL_W-1:0] tab_size_ff, tab_size_in;
   logic [COL_W-1:0] column_limit_ff, column_limit_in;
   front_item_type   f_item;
   logic             f_empty;
   logic             f_pop;
   out_item_type     b_item;
   logic             b_push;
   logic             o_full;
   logic [$bits(out_item_type)-1:0] o_rd_data;
   out_item_type     o_item;

   always_comb begin
      tab_size_in     = tab_size_ff;
      column_limit_in = column_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CFG_TAB_SIZE:     tab_size_in     = csr_wr_data;
            CFG_COLUMN_LIMIT: column_limit_in = csr_wr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_size_ff     <= TAB_SIZE_RST;
         column_limit_ff <= COL_LIMIT_RST;
      end else begin
         tab_size_ff     <= tab_size_in;
         column_limit_ff <= column_limit_in;
      end
   end

   lfte_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .in_char (req_in_char),
      .full    (full),
      .pop     (f_pop),
      .item    (f_item),
      .empty   (f_empty)
   );

   lfte_back #(
      .WORD_DEPTH (WORD_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .tab      (clamp_reg(tab_size_ff)),
      .limit    (clamp_reg(column_limit_ff)),
      .in_item  (f_item),
      .in_empty (f_empty),
      .in_pop   (f_pop),
      .out_item (b_item),
      .out_push (b_push),
      .out_full (o_full)
   );

   lfte_fifo #(
      .WIDTH ($bits(out_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (b_push),
      .wr_data (b_item),
      .full    (o_full),
      .pop     (pop),
      .rd_data (o_rd_data),
      .empty   (empty)
   );

   assign o_item           = out_item_type'(o_rd_data);
   assign rsp_out_char     = o_item.out_char;
   assign rsp_repeat_count = o_item.repeat_count;
   assign rsp_last_of_run  = o_item.last_of_run;

endmodule

>>> design/lfte_fifo.sv
// ----------------------------------------------------------------------------
// Line folder queue
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lfte_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> design/lfte_mod.sv
// ----------------------------------------------------------------------------
// Line folder remainder unit
// Restoring remainder, one dividend bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module lfte_mod
   import lfte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   logic [SUM_W-1:0]     div_ff, div_in;
   logic [COL_W-1:0]     rem_ff, rem_in;
   logic [COL_W-1:0]     dsr_ff, dsr_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [SUM_W-1:0]     trial;
   logic                 busy;

   assign busy  = (cnt_ff != '0);
   assign trial = {rem_ff, div_ff[SUM_W-1]};

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         div_in = req.dividend;
         dsr_in = req.divisor;
         rem_in = '0;
         cnt_in = MOD_CNT_W'(SUM_W);
      end else if (busy) begin
         div_in = {div_ff[SUM_W-2:0], 1'b0};
         if (trial >= SUM_W'(dsr_ff)) begin
            rem_in = COL_W'(trial - SUM_W'(dsr_ff));
         end else begin
            rem_in = trial[COL_W-1:0];
         end
         cnt_in  = cnt_ff - MOD_CNT_W'(1);
         done_in = (cnt_ff == MOD_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

>>> design/lfte_front.sv
// ----------------------------------------------------------------------------
// Line folder front end
// Classify each accepted byte and queue it for the sequencer.
// ----------------------------------------------------------------------------
module lfte_front
   import lfte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [CHAR_W-1:0] in_char,
   output logic              full,
   input  logic              pop,
   output front_item_type    item,
   output logic              empty
);

   front_item_type            classed;
   logic [$bits(front_item_type)-1:0] q_rd_data;

   always_comb begin
      classed.ch = in_char;
      case (in_char)
         CH_SPACE:   classed.cls = CLS_SPACE;
         CH_TAB:     classed.cls = CLS_TAB;
         CH_NEWLINE: classed.cls = CLS_NEWLINE;
         default:    classed.cls = CLS_WORD;
      endcase
   end

   lfte_fifo #(
      .WIDTH ($bits(front_item_type)),
      .DEPTH (FRONT_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (classed),
      .full    (full),
      .pop     (pop),
      .rd_data (q_rd_data),
      .empty   (empty)
   );

   assign item = front_item_type'(q_rd_data);

endmodule

>>> design/lfte_back.sv
// ----------------------------------------------------------------------------
// Line folder sequencer
// Place words, track column and blanks, expand tabs and fold lines.
// ----------------------------------------------------------------------------
`include "line_fold_with_tab_expansion_defines.svh"

module lfte_back
   import lfte_pkg::*;
#(
   parameter int WORD_DEPTH = 62
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [COL_W-1:0] tab,
   input  logic [COL_W-1:0] limit,
   input  front_item_type   in_item,
   input  logic             in_empty,
   output logic             in_pop,
   output out_item_type     out_item,
   output logic             out_push,
   input  logic             out_full
);

   localparam int PTR_W = $clog2(WORD_DEPTH);
   localparam int LEN_W = $clog2(WORD_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PLACE_NL,
      S_PLACE_CH,
      S_WS_BLANK,
      S_MOD,
      S_FLUSH,
      S_BREAK,
      S_FULL_NL
   } state_type;

   state_type         state_ff, state_in;
   item_class_type    cls_ff, cls_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [COL_W-1:0]  pending_ff, pending_in;
   logic              after_blank_ff, after_blank_in;
   logic              suppress_ff, suppress_in;
   logic [LEN_W-1:0]  wl_ff, wl_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [CHAR_W-1:0] hold_char_ff, hold_char_in;
   logic [COL_W-1:0]  hold_rep_ff, hold_rep_in;
   logic [CHAR_W-1:0] rd_data_ff;

   logic [CHAR_W-1:0] word_mem [WORD_DEPTH];

   logic              emit_go;
   logic              emit_req;
   logic [CHAR_W-1:0] emit_char;
   logic [COL_W-1:0]  emit_rep;
   logic              st_we;
   logic [SUM_W-1:0]  col_plus_wl;
   logic [SUM_W-1:0]  col_plus_pend;
   logic [COL_W-1:0]  pend_nx;
   logic [SUM_W-1:0]  blank_sum;
   logic [COL_W-1:0]  tab_pend;
   logic [SUM_W-1:0]  tab_sum;
   mod_req_type       mod_req;
   mod_rsp_type       mod_rsp;

   assign emit_go       = !out_full;
   assign col_plus_wl   = SUM_W'(column_ff) + SUM_W'(wl_ff);
   assign col_plus_pend = SUM_W'(column_ff) + SUM_W'(pending_ff);
   assign pend_nx       = suppress_ff ? pending_ff
                                      : sat_col(SUM_W'(pending_ff) + SUM_W'(1));
   assign blank_sum     = SUM_W'(column_ff) + SUM_W'(pend_nx);
   assign tab_pend      = tab - mod_rsp.remainder;
   assign tab_sum       = SUM_W'(column_ff) + SUM_W'(tab_pend);

   always_comb begin
      state_in       = state_ff;
      cls_in         = cls_ff;
      ch_in          = ch_ff;
      column_in      = column_ff;
      pending_in     = pending_ff;
      after_blank_in = after_blank_ff;
      suppress_in    = suppress_ff;
      wl_in          = wl_ff;
      ptr_in         = ptr_ff;
      hold_valid_in  = hold_valid_ff;
      hold_char_in   = hold_char_ff;
      hold_rep_in    = hold_rep_ff;
      emit_req       = 1'b0;
      emit_char      = CH_NEWLINE;
      emit_rep       = COL_W'(1);
      st_we          = 1'b0;
      in_pop         = 1'b0;
      out_push       = 1'b0;
      out_item       = '{out_char: hold_char_ff, repeat_count: hold_rep_ff, last_of_run: 1'b0};
      mod_req        = '{start: 1'b0, dividend: blank_sum, divisor: tab};

      case (state_ff)
         S_IDLE: begin
            if (hold_valid_ff && emit_go) begin
               out_push             = 1'b1;
               out_item.last_of_run = 1'b1;
               hold_valid_in        = 1'b0;
            end
            if ((!hold_valid_ff || emit_go) && !in_empty) begin
               in_pop = 1'b1;
               cls_in = in_item.cls;
               ch_in  = in_item.ch;
               if (in_item.cls == CLS_WORD) begin
                  after_blank_in = 1'b0;
                  suppress_in    = 1'b0;
                  state_in       = S_FLUSH;
               end else if (!after_blank_ff && wl_ff != '0) begin
                  after_blank_in = 1'b1;
                  state_in       = S_PLACE_NL;
               end else begin
                  state_in = S_WS_BLANK;
               end
            end
         end
         S_PLACE_NL: begin
            if (col_plus_wl > SUM_W'(limit)) begin
               if (emit_go) begin
                  emit_req  = 1'b1;
                  column_in = '0;
                  state_in  = S_PLACE_CH;
               end
            end else begin
               state_in = S_PLACE_CH;
            end
         end
         S_PLACE_CH: begin
            if (emit_go) begin
               emit_req  = 1'b1;
               emit_char = rd_data_ff;
               if (LEN_W'(ptr_ff) + LEN_W'(1) == wl_ff) begin
                  column_in = sat_col(col_plus_wl);
                  wl_in     = '0;
                  ptr_in    = '0;
                  state_in  = (cls_ff == CLS_WORD) ? S_FULL_NL : S_WS_BLANK;
               end else begin
                  ptr_in = ptr_ff + PTR_W'(1);
               end
            end
         end
         S_WS_BLANK: begin
            pending_in = pend_nx;
            case (cls_ff)
               CLS_SPACE: begin
                  if (blank_sum > SUM_W'(limit)) begin
                     state_in = S_BREAK;
                  end else begin
                     mod_req.start = 1'b1;
                     state_in      = S_MOD;
                  end
               end
               CLS_TAB: begin
                  mod_req.start    = 1'b1;
                  mod_req.dividend = SUM_W'(column_ff);
                  state_in         = S_MOD;
               end
               CLS_NEWLINE: state_in = S_BREAK;
               default:     state_in = S_IDLE;
            endcase
         end
         S_MOD: begin
            if (mod_rsp.done) begin
               if (cls_ff == CLS_TAB) begin
                  pending_in = tab_pend;
                  state_in   = (tab_sum > SUM_W'(limit)) ? S_BREAK : S_FLUSH;
               end else begin
                  state_in = (mod_rsp.remainder == '0) ? S_FLUSH : S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (pending_ff == '0 || emit_go) begin
               if (pending_ff != '0) begin
                  emit_req   = 1'b1;
                  emit_char  = CH_SPACE;
                  emit_rep   = pending_ff;
                  column_in  = sat_col(col_plus_pend);
                  pending_in = '0;
               end
               if (cls_ff != CLS_WORD) begin
                  state_in = S_IDLE;
               end else if (wl_ff == LEN_W'(WORD_DEPTH)) begin
                  state_in = S_PLACE_NL;
               end else begin
                  st_we    = 1'b1;
                  wl_in    = wl_ff + LEN_W'(1);
                  state_in = S_IDLE;
               end
            end
         end
         S_BREAK: begin
            if (emit_go) begin
               emit_req    = 1'b1;
               suppress_in = 1'b1;
               column_in   = '0;
               pending_in  = '0;
               state_in    = S_IDLE;
            end
         end
         S_FULL_NL: begin
            if (emit_go) begin
               emit_req  = 1'b1;
               column_in = '0;
               st_we     = 1'b1;
               wl_in     = wl_ff + LEN_W'(1);
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // hand the held result on, keep the new one until we know if it ends the item
      if (emit_req) begin
         out_push      = hold_valid_ff;
         hold_valid_in = 1'b1;
         hold_char_in  = emit_char;
         hold_rep_in   = emit_rep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         column_ff      <= '0;
         pending_ff     <= '0;
         after_blank_ff <= 1'b0;
         suppress_ff    <= 1'b0;
         wl_ff          <= '0;
         ptr_ff         <= '0;
         hold_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         column_ff      <= column_in;
         pending_ff     <= pending_in;
         after_blank_ff <= after_blank_in;
         suppress_ff    <= suppress_in;
         wl_ff          <= wl_in;
         ptr_ff         <= ptr_in;
         hold_valid_ff  <= hold_valid_in;
      end
      cls_ff       <= cls_in;
      ch_ff        <= ch_in;
      hold_char_ff <= hold_char_in;
      hold_rep_ff  <= hold_rep_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) word_mem[wl_ff[PTR_W-1:0]] <= ch_ff;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= word_mem[ptr_in];
   end

   lfte_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   `LFTE_ASSERT_IMP(a_place_nonempty, state_ff == S_PLACE_CH, wl_ff != '0, "placing an empty word")
   `LFTE_ASSERT_IMP(a_mod_done_waited, mod_rsp.done, state_ff == S_MOD, "remainder unit done out of turn")
   `LFTE_ASSERT_IMP(a_push_room, out_push, !out_full, "push into full result queue")
   `LFTE_ASSERT_NEXT(a_break_clears, (state_ff == S_BREAK) && !out_full, (column_ff == '0) && suppress_ff && (pending_ff == '0), "line break left column or blanks")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Line folder testbench
// Streams text bytes into the folder with random gaps on both sides, predicts
// the folded output with a behavioral model of word wrap and tab expansion,
// and checks every output word field by field in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfte_pkg::*;

   localparam int WORD_DEPTH   = 62;
   localparam int MAX_GLYPHS   = 64;
   localparam int DRAIN_CYCLES = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [CHAR_W-1:0]    req_in_char = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [CHAR_W-1:0]    rsp_out_char;
   logic [COL_W-1:0]     rsp_repeat_count;
   logic                 rsp_last_of_run;
   logic                 csr_wr_en = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [COL_W-1:0]     csr_wr_data = '0;

   line_fold_with_tab_expansion #(
      .WORD_DEPTH(WORD_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_char(req_in_char),
      .empty(empty),
      .pop(pop),
      .rsp_out_char(rsp_out_char),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // fold predictor state
   logic [COL_W-1:0]  tab_reg = TAB_SIZE_RST;
   logic [COL_W-1:0]  limit_reg = COL_LIMIT_RST;
   logic [COL_W-1:0]  cur_col = '0;
   logic [COL_W-1:0]  held_blanks = '0;
   logic [COL_W-1:0]  word_len = '0;
   logic              saw_blank = 1'b0;
   logic              mute_blanks = 1'b0;
   logic [CHAR_W-1:0] word_buf [WORD_DEPTH];
   int                glyphs_this_byte;

   out_item_type      expected_glyphs [$];
   int                mismatches = 0;
   bit                jitter_on = 1'b1;
   int                pop_stall = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic item_class_type classify(input logic [CHAR_W-1:0] c);
      if (c == CH_SPACE) return CLS_SPACE;
      if (c == CH_TAB) return CLS_TAB;
      if (c == CH_NEWLINE) return CLS_NEWLINE;
      return CLS_WORD;
   endfunction

   function automatic int eff_reg(input logic [COL_W-1:0] v);
      if (v < REG_MIN) return int'(REG_MIN);
      if (v > REG_MAX) return int'(REG_MAX);
      return int'(v);
   endfunction

   function automatic logic [COL_W-1:0] sat_count(input int v);
      if (v > int'(COL_SAT)) return COL_SAT;
      return COL_W'(v);
   endfunction

   function automatic logic [CHAR_W-1:0] word_byte();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255)); while (classify(c) != CLS_WORD);
      return c;
   endfunction

   task automatic emit_glyph(input logic [CHAR_W-1:0] ch, input logic [COL_W-1:0] rep);
      out_item_type g;
      if (glyphs_this_byte < MAX_GLYPHS) begin
         g.out_char = ch;
         g.repeat_count = rep;
         g.last_of_run = 1'b0;
         expected_glyphs.push_back(g);
         glyphs_this_byte++;
      end
   endtask

   task automatic release_blanks();
      if (held_blanks != 0) begin
         emit_glyph(CH_SPACE, held_blanks);
         cur_col = sat_count(int'(cur_col) + int'(held_blanks));
         held_blanks = '0;
      end
   endtask

   task automatic place_word(input int lim);
      if (int'(cur_col) + int'(word_len) > lim) begin
         emit_glyph(CH_NEWLINE, 6'd1);
         cur_col = '0;
      end
      for (int i = 0; i < int'(word_len); i++) emit_glyph(word_buf[i], 6'd1);
      cur_col = sat_count(int'(cur_col) + int'(word_len));
      word_len = '0;
   endtask

   task automatic break_line();
      emit_glyph(CH_NEWLINE, 6'd1);
      mute_blanks = 1'b1;
      cur_col = '0;
      held_blanks = '0;
   endtask

   task automatic fold_byte(input logic [CHAR_W-1:0] c);
      int tab;
      int lim;
      item_class_type cls;
      tab = eff_reg(tab_reg);
      lim = eff_reg(limit_reg);
      cls = classify(c);
      glyphs_this_byte = 0;
      if (cls != CLS_WORD) begin
         if (!saw_blank && word_len != 0) begin
            saw_blank = 1'b1;
            place_word(lim);
         end
         if (!mute_blanks) held_blanks = sat_count(int'(held_blanks) + 1);
         case (cls)
            CLS_SPACE: begin
               if (int'(cur_col) + int'(held_blanks) > lim) break_line();
               else if ((int'(cur_col) + int'(held_blanks)) % tab == 0) release_blanks();
            end
            CLS_TAB: begin
               held_blanks = COL_W'(tab - int'(cur_col) % tab);
               if (int'(cur_col) + int'(held_blanks) > lim) break_line();
               else release_blanks();
            end
            default: break_line();
         endcase
      end else begin
         saw_blank = 1'b0;
         mute_blanks = 1'b0;
         release_blanks();
         if (int'(word_len) >= WORD_DEPTH) begin
            place_word(lim);
            emit_glyph(CH_NEWLINE, 6'd1);
            cur_col = '0;
         end
         if (int'(word_len) < WORD_DEPTH) begin
            word_buf[word_len] = c;
            word_len = word_len + 1'b1;
         end
      end
      if (glyphs_this_byte > 0)
         expected_glyphs[expected_glyphs.size()-1].last_of_run = 1'b1;
   endtask

   task automatic send_byte(input logic [CHAR_W-1:0] c);
      req_in_char <= c;
      push <= 1'b1;
      do @(posedge clock); while (full);
      fold_byte(c);
      if (jitter_on && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // hold until every expected word is out, then let trailing blanks settle
   task automatic settle();
      push <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [COL_W-1:0] tab, input logic [COL_W-1:0] lim);
      csr_wr_en <= 1'b1;
      csr_index <= CFG_TAB_SIZE;
      csr_wr_data <= tab;
      @(posedge clock);
      csr_index <= CFG_COLUMN_LIMIT;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tab_reg = tab;
      limit_reg = lim;
   endtask

   task automatic gen_text(input int count);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 10);
            repeat (len) send_byte(word_byte());
            sent += len;
         end else if (pick < 15) begin
            len = $urandom_range(1, 4);
            repeat (len) send_byte(CH_SPACE);
            sent += len;
         end else if (pick < 17) begin
            send_byte(CH_TAB);
            sent++;
         end else if (pick < 18) begin
            send_byte(CH_NEWLINE);
            sent++;
         end else begin
            send_byte(CHAR_W'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte("a");
      send_byte(CH_SPACE);
      send_byte(CH_SPACE);
      send_byte(CH_TAB);
      send_byte("b");
      send_byte(CH_NEWLINE);
      send_byte(CH_TAB);
      send_byte(CH_SPACE);
      send_byte("c");
      send_byte(CH_NEWLINE);
      settle();
      set_regs(6'd0, 6'd63);
      send_byte("x");
      send_byte(CH_TAB);
      send_byte(CH_SPACE);
      send_byte("y");
      send_byte(CH_NEWLINE);
      settle();
      set_regs(6'd63, 6'd0);
      send_byte("p");
      send_byte("q");
      send_byte(CH_SPACE);
      send_byte(CH_SPACE);
      send_byte(CH_TAB);
      send_byte("r");
      send_byte(CH_NEWLINE);
      settle();
   endtask

   task automatic test_full_word();
      set_regs(6'd8, 6'd62);
      send_byte("a");
      send_byte("b");
      send_byte(CH_SPACE);
      repeat (WORD_DEPTH + 2) send_byte(word_byte());
      send_byte(CH_NEWLINE);
      settle();
   endtask

   task automatic test_shrink_limit();
      set_regs(6'd62, 6'd62);
      repeat (10) send_byte(word_byte());
      repeat (45) send_byte(CH_SPACE);
      settle();
      set_regs(6'd1, 6'd5);
      send_byte(word_byte());
      send_byte(CH_TAB);
      send_byte(CH_SPACE);
      gen_text(10);
      settle();
   endtask

   task automatic test_random_text(input logic [COL_W-1:0] tab, input logic [COL_W-1:0] lim,
                                   input int count);
      set_regs(tab, lim);
      gen_text(count);
      settle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_stall = 0;
      end else if (pop_stall > 0) begin
         pop <= 1'b0;
         pop_stall--;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
         pop <= 1'b0;
         pop_stall = $urandom_range(0, 2);
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      out_item_type want;
      if (!reset && pop && !empty) begin
         if (expected_glyphs.size() == 0) begin
            $error("unexpected word: out_char %h repeat_count %0d last_of_run %b",
                   rsp_out_char, rsp_repeat_count, rsp_last_of_run);
            mismatches++;
         end else begin
            want = expected_glyphs.pop_front();
            if (rsp_out_char !== want.out_char) begin
               $error("out_char: expected %h, actual %h", want.out_char, rsp_out_char);
               mismatches++;
            end
            if (rsp_repeat_count !== want.repeat_count) begin
               $error("repeat_count: expected %0d, actual %0d",
                      want.repeat_count, rsp_repeat_count);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, actual %b", want.last_of_run, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_word();
      test_shrink_limit();
      test_random_text(6'd8, 6'd62, 14);
      test_random_text(6'd1, 6'd1, 14);
      test_random_text(6'd62, 6'd62, 14);
      test_random_text(COL_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)), 14);
      jitter_on = 1'b0;
      test_random_text(6'd3, 6'd17, 14);
      if (mismatches == 0 && expected_glyphs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
